// ----- sv/sbb_pkg.sv -----
// shared types, constants and the divide-by-three helper for the box blur
package sbb_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned DimW      = 9;
  localparam int unsigned PixW      = 8;
  localparam int unsigned SumW      = 10;
  localparam int unsigned JobDepth  = 4;
  localparam int unsigned JobPtrW   = $clog2(JobDepth);
  localparam int unsigned JobCntW   = $clog2(JobDepth + 1);

  localparam logic [DimW-1:0] DimMin      = DimW'(2);
  localparam logic [DimW-1:0] WidthMax    = DimW'(MaxWidth);
  localparam logic [DimW-1:0] HeightMax   = DimW'(MaxHeight);
  localparam logic [DimW-1:0] DimResetVal = DimW'(256);

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // one column job: a horizontal result and what it completes
  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [PixW-1:0] hval;
    logic            emit_upper;
    logic            emit_lower;
    logic            use_older;
    logic            eof_col;
    logic            last_job;
  } job_t;

  // one result item
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
    logic            eof;
  } res_t;

  // floor(x / 3) for x up to 767, by reciprocal multiply
  function automatic logic [PixW-1:0] div3(input logic [SumW-1:0] x);
    logic [19:0] prod;
    prod = 20'(x) * 20'd683;
    return prod[18:11];
  endfunction

endpackage

// ----- sv/sbb_front.sv -----
// front end: position tracking, horizontal pass and column job issue
module sbb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sbb_pkg::DimW-1:0]     frame_width_i,
  input  logic [sbb_pkg::DimW-1:0]     frame_height_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sbb_pkg::PixW-1:0]     pixel_in_i,
  input  logic                         room2_i,
  output logic                         push0_o,
  output logic                         push1_o,
  output sbb_pkg::job_t                job0_o,
  output sbb_pkg::job_t                job1_o
);
  import sbb_pkg::*;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [PixW-1:0] prev_q, prev2_q;
  logic [DimW-1:0] w_use, h_use;
  logic            wrap_col;
  logic [DimW-1:0] row_adj9;
  logic [ColW-1:0] c;
  logic [RowW-1:0] r;
  logic [DimW-1:0] c9, c_next9, r_next9;
  logic [PixW-1:0] left;
  logic [SumW-1:0] sum3, sum2;
  logic            accept, has_job, end_col;
  logic            emit_upper, emit_lower, use_older;

  // clamp geometry to the supported range
  always_comb begin
    w_use = frame_width_i;
    if (frame_width_i < DimMin) w_use = DimMin;
    else if (frame_width_i > WidthMax) w_use = WidthMax;
    h_use = frame_height_i;
    if (frame_height_i < DimMin) h_use = DimMin;
    else if (frame_height_i > HeightMax) h_use = HeightMax;
  end

  // position of this pixel after geometry fix-up
  always_comb begin
    wrap_col = {1'b0, col_q} >= w_use;
    row_adj9 = wrap_col ? ({1'b0, row_q} + DimW'(1)) : {1'b0, row_q};
    c        = wrap_col ? '0 : col_q;
    r        = (row_adj9 >= h_use) ? '0 : row_adj9[RowW-1:0];
    c9       = {1'b0, c};
  end

  assign in_ready_o = room2_i;
  assign accept     = in_valid_i & room2_i;
  assign has_job    = c != '0;
  assign end_col    = c9 == (w_use - DimW'(1));

  // horizontal sums
  always_comb begin
    left = (c9 >= DimW'(2)) ? prev2_q : '0;
    sum3 = SumW'(left) + SumW'(prev_q) + SumW'(pixel_in_i);
    sum2 = SumW'(prev_q) + SumW'(pixel_in_i);
  end

  // row classification shared by both jobs
  assign emit_upper = r != '0;
  assign emit_lower = {1'b0, r} == (h_use - DimW'(1));
  assign use_older  = {1'b0, r} >= DimW'(2);

  // job for the column left of this pixel, and for the last column at row end
  always_comb begin
    job0_o.col        = c - ColW'(1);
    job0_o.row        = r;
    job0_o.hval       = div3(sum3);
    job0_o.emit_upper = emit_upper;
    job0_o.emit_lower = emit_lower;
    job0_o.use_older  = use_older;
    job0_o.eof_col    = 1'b0;
    job0_o.last_job   = ~end_col;

    job1_o.col        = c;
    job1_o.row        = r;
    job1_o.hval       = div3(sum2);
    job1_o.emit_upper = emit_upper;
    job1_o.emit_lower = emit_lower;
    job1_o.use_older  = use_older;
    job1_o.eof_col    = 1'b1;
    job1_o.last_job   = 1'b1;
  end

  assign push0_o = accept & has_job;
  assign push1_o = accept & has_job & end_col;

  // next position
  always_comb begin
    c_next9 = c9 + DimW'(1);
    r_next9 = {1'b0, r} + DimW'(1);
    col_d   = c_next9[ColW-1:0];
    row_d   = r;
    if (c_next9 == w_use) begin
      col_d = '0;
      row_d = (r_next9 == h_use) ? '0 : r_next9[RowW-1:0];
    end
  end

  // position and pixel history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      prev_q  <= '0;
      prev2_q <= '0;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      prev_q  <= pixel_in_i;
      prev2_q <= prev_q;
    end
  end

endmodule

// ----- sv/sbb_job_fifo.sv -----
// short job queue between front and back, two writes and one read per cycle
module sbb_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push0_i,
  input  logic          push1_i,
  input  sbb_pkg::job_t job0_i,
  input  sbb_pkg::job_t job1_i,
  output logic          room2_o,
  input  logic          pop_i,
  output logic          not_empty_o,
  output sbb_pkg::job_t head_o
);
  import sbb_pkg::*;

  job_t               slot_q [JobDepth];
  logic [JobPtrW-1:0] wp_q, rp_q;
  logic [JobCntW-1:0] cnt_q;
  logic [JobPtrW-1:0] wp_plus1;
  logic               do_pop;

  assign wp_plus1    = wp_q + JobPtrW'(1);
  assign not_empty_o = cnt_q != '0;
  assign room2_o     = cnt_q <= JobCntW'(JobDepth - 2);
  assign head_o      = slot_q[rp_q];
  assign do_pop      = pop_i & not_empty_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (push0_i) slot_q[wp_q] <= job0_i;
    if (push1_i) slot_q[wp_plus1] <= job1_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + JobPtrW'(push0_i) + JobPtrW'(push1_i);
      rp_q  <= rp_q + JobPtrW'(do_pop);
      cnt_q <= cnt_q + JobCntW'(push0_i) + JobCntW'(push1_i) - JobCntW'(do_pop);
    end
  end

endmodule

// ----- sv/sbb_back.sv -----
// back end: line store, vertical pass and result sequencing
module sbb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           not_empty_i,
  input  sbb_pkg::job_t  head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sbb_pkg::res_t  res_o
);
  import sbb_pkg::*;

  localparam int unsigned LineW = 2 * PixW;

  // line store: upper byte holds row r-2, lower byte row r-1
  logic [LineW-1:0] line_mem [MaxWidth];
  logic [LineW-1:0] rd_q, fwd_data_q, entry, wr_data;
  logic             fwd_q;
  logic             we;

  logic             b_valid_q, up_done_q;
  job_t             b_job_q;
  logic [PixW-1:0]  a_val, b_val;
  logic [SumW-1:0]  up_sum, lo_sum;
  logic             up_pend, has_res, is_last_res;
  logic             out_free, out_load, b_leave, b_accept;
  res_t             cur_res;
  logic             out_valid_q;
  res_t             out_q;

  assign entry   = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {entry[PixW-1:0], b_job_q.hval};

  // vertical sums with rows above the frame gated to zero
  always_comb begin
    a_val  = b_job_q.use_older ? entry[LineW-1:PixW] : '0;
    b_val  = b_job_q.emit_upper ? entry[PixW-1:0] : '0;
    up_sum = SumW'(a_val) + SumW'(b_val) + SumW'(b_job_q.hval);
    lo_sum = SumW'(b_val) + SumW'(b_job_q.hval);
  end

  // pick the pending result of the job in hand
  always_comb begin
    up_pend     = b_job_q.emit_upper & ~up_done_q;
    has_res     = up_pend | b_job_q.emit_lower;
    is_last_res = up_pend ? ~b_job_q.emit_lower : 1'b1;
    cur_res.pixel = up_pend ? div3(up_sum) : div3(lo_sum);
    cur_res.row   = up_pend ? (b_job_q.row - RowW'(1)) : b_job_q.row;
    cur_res.col   = b_job_q.col;
    cur_res.last  = b_job_q.last_job & is_last_res;
    cur_res.eof   = ~up_pend & b_job_q.eof_col;
  end

  assign out_free = ~out_valid_q | out_ready_i;
  assign out_load = b_valid_q & has_res & out_free;
  assign b_leave  = b_valid_q & (~has_res | (out_load & is_last_res));
  assign b_accept = ~b_valid_q | b_leave;
  assign pop_o    = not_empty_i & b_accept;
  assign we       = b_leave;

  // line store access, read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we) line_mem[b_job_q.col] <= wr_data;
    if (pop_o) begin
      rd_q       <= line_mem[head_i.col];
      fwd_data_q <= wr_data;
      b_job_q    <= head_i;
    end
  end

  // bypass flag for a read that met a write to the same column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (pop_o) begin
      fwd_q <= we & (b_job_q.col == head_i.col);
    end
  end

  // job stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      up_done_q <= 1'b0;
    end else if (b_accept) begin
      b_valid_q <= pop_o;
      up_done_q <= 1'b0;
    end else if (out_load && !is_last_res) begin
      up_done_q <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= cur_res;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ----- sv/separable_box_blur_3x3_unit.sv -----
// top level of the separable 3x3 box blur: config registers and front/back hookup
// throughput: one item per cycle while the job queue has room for two jobs; in the last
//   row each column yields two results and the single result port of the back end
//   then sets the pace
// reset: position and pixel history clear, width and height go to 256; the line store
//   is not cleared, rows above the frame are masked to zero instead
module separable_box_blur_3x3_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [sbb_pkg::PixW-1:0]   pixel_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sbb_pkg::PixW-1:0]   pixel_out_o,
  output logic [sbb_pkg::RowW-1:0]   out_row_o,
  output logic [sbb_pkg::ColW-1:0]   out_col_o,
  output logic                       last_of_run_o,
  output logic                       end_of_frame_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [0:0]                 cfg_index_i,
  input  logic [sbb_pkg::DimW-1:0]   cfg_data_i
);
  import sbb_pkg::*;

  logic [DimW-1:0] frame_width_q, frame_height_q;
  logic            room2, push0, push1, pop, not_empty;
  job_t            job0, job1, head;
  res_t            res;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DimResetVal;
      frame_height_q <= DimResetVal;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end
  sbb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_in_i     (pixel_in_i),
    .room2_i        (room2),
    .push0_o        (push0),
    .push1_o        (push1),
    .job0_o         (job0),
    .job1_o         (job1)
  );

  // job queue
  sbb_job_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (push0),
    .push1_i     (push1),
    .job0_i      (job0),
    .job1_i      (job1),
    .room2_o     (room2),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .head_o      (head)
  );

  // back end
  sbb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .not_empty_i (not_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign pixel_out_o    = res.pixel;
  assign out_row_o      = res.row;
  assign out_col_o      = res.col;
  assign last_of_run_o  = res.last;
  assign end_of_frame_o = res.eof;

endmodule
